FILE: hw/rtl/micedec_pkg.sv
`default_nettype none

package micedec_pkg;

  localparam int unsigned NumAddrChars = 6;

  localparam logic [7:0] TYPE_CUR_GPS  = 8'h60;
  localparam logic [7:0] TYPE_OLD_GPS  = 8'h27;
  localparam logic [7:0] TYPE_CUR_RSV  = 8'h1c;
  localparam logic [7:0] TYPE_OLD_RSV  = 8'h1d;

  localparam logic [7:0] XTRA_BACKTICK = 8'h60;
  localparam logic [7:0] XTRA_GT       = 8'h3e;
  localparam logic [7:0] XTRA_RBRACKET = 8'h5d;

  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_A    = 8'h41;
  localparam logic [7:0] CHR_K    = 8'h4b;
  localparam logic [7:0] CHR_L    = 8'h4c;
  localparam logic [7:0] CHR_P    = 8'h50;
  localparam logic [7:0] CHR_Z    = 8'h5a;

  localparam logic [3:0] MSG_EMERGENCY = 4'd7;
  localparam logic [3:0] MSG_UNKNOWN   = 4'd8;

  typedef struct packed {
    logic       legal;
    logic [3:0] digit;
    logic       blank;
    logic       flag;
    logic       custom;
  } addr_dec_t;

  function automatic addr_dec_t decode_addr(input logic [7:0] c);
    addr_dec_t r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff    = c - CHR_ZERO;
      r.legal = 1'b1;
      r.digit = diff[3:0];
    end else if (c inside {[8'h41:8'h4a]}) begin
      diff     = c - CHR_A;
      r.legal  = 1'b1;
      r.digit  = diff[3:0];
      r.flag   = 1'b1;
      r.custom = 1'b1;
    end else if (c == CHR_K) begin
      r.legal  = 1'b1;
      r.blank  = 1'b1;
      r.flag   = 1'b1;
      r.custom = 1'b1;
    end else if (c == CHR_L) begin
      r.legal = 1'b1;
      r.blank = 1'b1;
    end else if (c inside {[8'h50:8'h59]}) begin
      diff    = c - CHR_P;
      r.legal = 1'b1;
      r.digit = diff[3:0];
      r.flag  = 1'b1;
    end else if (c == CHR_Z) begin
      r.legal = 1'b1;
      r.blank = 1'b1;
      r.flag  = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mic_e_position_decoder_unit.sv
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata 128 b report bytes, tuser extra_present
// m_axis   | out | m_axis_tvalid/tready   | tdata 96 b decoded fields, tuser report_valid
//
// One report per cycle while the output is not stalled; a report passes through the decode,
// the partial-product and the final-sum register stages.
// rst_ni clears the stage valid bits only.
// A stalled output holds all three stages; input ready is output ready or an empty last stage.
`default_nettype none

module mic_e_position_decoder_unit
  import micedec_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // dest_chars[47:0], data_type_byte[55:48], lon_bytes[79:56],
  // speed_course_bytes[103:80], symbol_bytes[119:104], extra_byte[127:120]
  input  wire logic [127:0] s_axis_tdata,
  // extra_present[0]
  input  wire logic         s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // latitude_hmin[20:0], longitude_hmin[42:21], ambiguity_level[45:43],
  // msg_code[49:46], custom_message[50], ground_speed[61:51],
  // heading[71:62], symbol_code[79:72], symbol_table[87:80],
  // msg_support[88], null_position[89], zero fill [95:90]
  output      logic [95:0]  m_axis_tdata,
  // report_valid[0]
  output      logic         m_axis_tuser
);

  logic adv;
  logic v1_q, v2_q, v3_q;

  assign adv           = !v3_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v3_q;

  // stage 1: character decode, byte offsets
  logic [47:0] in_dest;
  logic [7:0]  in_dtype, in_extra;
  logic [23:0] in_lon, in_spc;
  logic [15:0] in_sym;

  assign in_dest  = s_axis_tdata[47:0];
  assign in_dtype = s_axis_tdata[55:48];
  assign in_lon   = s_axis_tdata[79:56];
  assign in_spc   = s_axis_tdata[103:80];
  assign in_sym   = s_axis_tdata[119:104];
  assign in_extra = s_axis_tdata[127:120];

  addr_dec_t          ad_d [NumAddrChars];
  addr_dec_t          ad_q [NumAddrChars];
  logic               ok1_d, ok1_q;
  logic signed [8:0]  dr_raw, mr_raw, hr_raw;
  logic signed [9:0]  d1_d, d1_q;
  logic signed [8:0]  m1_d, m1_q;
  logic [6:0]         h1_d, h1_q;
  logic signed [8:0]  sp1_d, sp1_q, dc1_d, dc1_q, se1_d, se1_q;
  logic               cap1_d, cap1_q;
  logic [15:0]        sym1_q;

  always_comb begin
    ok1_d = (in_dtype == TYPE_CUR_GPS) || (in_dtype == TYPE_OLD_GPS) ||
            (in_dtype == TYPE_CUR_RSV) || (in_dtype == TYPE_OLD_RSV);
    for (int i = 0; i < NumAddrChars; i++) begin
      ad_d[i] = decode_addr(in_dest[47 - 8 * i -: 8]);
      ok1_d   = ok1_d && ad_d[i].legal;
    end
    dr_raw = $signed({1'b0, in_lon[23:16]}) - 9'sd28;
    mr_raw = $signed({1'b0, in_lon[15:8]}) - 9'sd28;
    hr_raw = $signed({1'b0, in_lon[7:0]}) - 9'sd28;
    d1_d   = 10'(dr_raw) + (ad_d[4].flag ? 10'sd100 : 10'sd0);
    m1_d   = (mr_raw >= 9'sd60) ? (mr_raw - 9'sd60) : mr_raw;
    if (hr_raw < 9'sd0) begin
      h1_d = '0;
    end else if (hr_raw > 9'sd99) begin
      h1_d = 7'd99;
    end else begin
      h1_d = hr_raw[6:0];
    end
    sp1_d  = $signed({1'b0, in_spc[23:16]}) - 9'sd28;
    dc1_d  = $signed({1'b0, in_spc[15:8]}) - 9'sd28;
    se1_d  = $signed({1'b0, in_spc[7:0]}) - 9'sd28;
    cap1_d = s_axis_tuser && ((in_extra == XTRA_BACKTICK) || (in_extra == XTRA_GT) ||
                              (in_extra == XTRA_RBRACKET));
  end

  // stage 2: digit sums, message code, longitude fixups, divide by ten
  logic [6:0]         lat_deg_d, lat_deg_q;
  logic [13:0]        lat_sub_d, lat_sub_q;
  logic [2:0]         amb_d, amb_q;
  logic [3:0]         code_d, code_q;
  logic               cust_d, cust_q;
  logic               any_std, any_cus;
  logic [2:0]         msg_idx;
  logic signed [9:0]  d2_d, d2_q;
  logic signed [8:0]  m2_q;
  logic [6:0]         h2_q;
  logic signed [12:0] sp10_d, sp10_q;
  logic [7:0]         dc_abs;
  logic [15:0]        dc_prod;
  logic [4:0]         dq_u;
  logic [7:0]         dr_u;
  logic signed [5:0]  dq_d, dq_q;
  logic signed [4:0]  drm_d, drm_q;
  logic signed [8:0]  se2_q;
  logic               ok2_q, neg_lat_q, neg_lon_q, cap2_q;
  logic [15:0]        sym2_q;

  always_comb begin
    lat_deg_d = 7'(ad_q[0].digit) * 7'd10 + 7'(ad_q[1].digit);
    lat_sub_d = 14'(ad_q[2].digit) * 14'd1000 + 14'(ad_q[3].digit) * 14'd100 +
                14'(ad_q[4].digit) * 14'd10 + 14'(ad_q[5].digit);

    if (!ad_q[5].blank) begin
      amb_d = 3'd0;
    end else if (!ad_q[4].blank) begin
      amb_d = 3'd1;
    end else if (!ad_q[3].blank) begin
      amb_d = 3'd2;
    end else if (!ad_q[2].blank) begin
      amb_d = 3'd3;
    end else begin
      amb_d = 3'd4;
    end

    msg_idx = {ad_q[0].flag, ad_q[1].flag, ad_q[2].flag};
    any_std = (ad_q[0].flag && !ad_q[0].custom) || (ad_q[1].flag && !ad_q[1].custom) ||
              (ad_q[2].flag && !ad_q[2].custom);
    any_cus = (ad_q[0].flag && ad_q[0].custom) || (ad_q[1].flag && ad_q[1].custom) ||
              (ad_q[2].flag && ad_q[2].custom);
    cust_d  = 1'b0;
    if (msg_idx == 3'd0) begin
      code_d = MSG_EMERGENCY;
    end else if (any_std && any_cus) begin
      code_d = MSG_UNKNOWN;
    end else begin
      code_d = MSG_EMERGENCY - {1'b0, msg_idx};
      cust_d = any_cus;
    end

    if (d1_q >= 10'sd180 && d1_q <= 10'sd189) begin
      d2_d = d1_q - 10'sd80;
    end else if (d1_q >= 10'sd190 && d1_q <= 10'sd199) begin
      d2_d = d1_q - 10'sd190;
    end else begin
      d2_d = d1_q;
    end

    sp10_d  = 13'(sp1_q) * 13'sd10;
    // truncating divide by ten on the magnitude, sign restored after
    dc_abs  = dc1_q[8] ? 8'(-dc1_q) : dc1_q[7:0];
    dc_prod = 16'(dc_abs) * 16'd205;
    dq_u    = dc_prod[15:11];
    dr_u    = dc_abs - 8'(dq_u) * 8'd10;
    dq_d    = dc1_q[8] ? -$signed({1'b0, dq_u}) : $signed({1'b0, dq_u});
    drm_d   = dc1_q[8] ? -$signed({1'b0, dr_u[3:0]}) : $signed({1'b0, dr_u[3:0]});
  end

  // stage 3: constant multiplies, wraps, clamps, output register
  logic [19:0]        lat_u;
  logic signed [20:0] lat_d, lat_q;
  logic signed [21:0] lon_mag, lon_d, lon_q;
  logic signed [12:0] spd_s, spd_w;
  logic signed [11:0] crs_s, crs_w;
  logic [10:0]        spd_d, spd_q;
  logic [9:0]         crs_d, crs_q;
  logic               null_d, null_q;
  logic               ok3_q, cust3_q, cap3_q;
  logic [2:0]         amb3_q;
  logic [3:0]         code3_q;
  logic [15:0]        sym3_q;

  always_comb begin
    lat_u   = 20'(lat_deg_q) * 20'd6000 + 20'(lat_sub_q);
    lat_d   = neg_lat_q ? -$signed({1'b0, lat_u}) : $signed({1'b0, lat_u});
    lon_mag = 22'(d2_q) * 22'sd6000 + 22'(m2_q) * 22'sd100 + $signed({15'd0, h2_q});
    lon_d   = neg_lon_q ? -lon_mag : lon_mag;
    spd_s   = sp10_q + 13'(dq_q);
    spd_w   = (spd_s >= 13'sd800) ? (spd_s - 13'sd800) : spd_s;
    spd_d   = spd_w[12] ? '0 : spd_w[10:0];
    crs_s   = 12'(drm_q) * 12'sd100 + 12'(se2_q);
    crs_w   = (crs_s >= 12'sd400) ? (crs_s - 12'sd400) : crs_s;
    crs_d   = crs_w[11] ? '0 : crs_w[9:0];
    null_d  = (lat_deg_q == 7'd0) && (lat_sub_q == 14'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ad_q      <= ad_d;
      ok1_q     <= ok1_d;
      d1_q      <= d1_d;
      m1_q      <= m1_d;
      h1_q      <= h1_d;
      sp1_q     <= sp1_d;
      dc1_q     <= dc1_d;
      se1_q     <= se1_d;
      cap1_q    <= cap1_d;
      sym1_q    <= in_sym;

      lat_deg_q <= lat_deg_d;
      lat_sub_q <= lat_sub_d;
      amb_q     <= amb_d;
      code_q    <= code_d;
      cust_q    <= cust_d;
      d2_q      <= d2_d;
      m2_q      <= m1_q;
      h2_q      <= h1_q;
      sp10_q    <= sp10_d;
      dq_q      <= dq_d;
      drm_q     <= drm_d;
      se2_q     <= se1_q;
      ok2_q     <= ok1_q;
      neg_lat_q <= !ad_q[3].flag;
      neg_lon_q <= ad_q[5].flag;
      cap2_q    <= cap1_q;
      sym2_q    <= sym1_q;

      lat_q     <= lat_d;
      lon_q     <= lon_d;
      spd_q     <= spd_d;
      crs_q     <= crs_d;
      null_q    <= null_d;
      ok3_q     <= ok2_q;
      cust3_q   <= cust_q;
      cap3_q    <= cap2_q;
      amb3_q    <= amb_q;
      code3_q   <= code_q;
      sym3_q    <= sym2_q;
    end
  end

  // zero every field of an invalid report
  always_comb begin
    m_axis_tuser = ok3_q;
    m_axis_tdata = '0;
    if (ok3_q) begin
      m_axis_tdata[20:0]  = lat_q;
      m_axis_tdata[42:21] = lon_q;
      m_axis_tdata[45:43] = amb3_q;
      m_axis_tdata[49:46] = code3_q;
      m_axis_tdata[50]    = cust3_q;
      m_axis_tdata[61:51] = spd_q;
      m_axis_tdata[71:62] = crs_q;
      m_axis_tdata[79:72] = sym3_q[15:8];
      m_axis_tdata[87:80] = sym3_q[7:0];
      m_axis_tdata[88]    = cap3_q;
      m_axis_tdata[89]    = null_q;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import micedec_pkg::*;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 12;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned RandomPhases   = 5;

  typedef struct packed {
    logic [7:0]  extra_byte;
    logic [15:0] symbol_bytes;
    logic [23:0] speed_course;
    logic [23:0] lon_bytes;
    logic [7:0]  data_type;
    logic [47:0] dest_chars;
  } report_bytes_t;

  typedef struct packed {
    logic          extra_present;
    report_bytes_t bytes;
  } mic_e_report_t;

  typedef struct packed {
    logic        null_position;
    logic        msg_support;
    logic [7:0]  symbol_table;
    logic [7:0]  symbol_code;
    logic [9:0]  heading;
    logic [10:0] ground_speed;
    logic        custom_message;
    logic [3:0]  msg_code;
    logic [2:0]  ambiguity;
    logic [21:0] longitude;
    logic [20:0] latitude;
  } fix_fields_t;

  typedef struct packed {
    logic        report_valid;
    fix_fields_t f;
  } position_fix_t;

  typedef struct {
    mic_e_report_t rpt;
    bit            typed;
    position_fix_t fix;
  } stim_row_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  position_fix_t pending_fixes[$];
  position_fix_t seen_fix;
  position_fix_t want_fix;

  int unsigned idle_pct         = 0;
  int unsigned stall_pct        = 0;
  int unsigned hold_off_request = 0;
  int unsigned cycle_count      = 0;
  int unsigned errors           = 0;
  int unsigned reports_sent     = 0;
  int unsigned results_checked  = 0;
  int unsigned fixes_valid      = 0;
  int unsigned directed_count   = 0;

  mic_e_position_decoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic position_fix_t decode_fix(mic_e_report_t r);
    position_fix_t fx;
    logic [7:0]    ch;
    int            dig[6];
    int            val[6];
    bit            flg[6];
    bit            cus[6];
    bit            ok;
    bit            any_std;
    bit            any_cus;
    logic [3:0]    sel;
    int            lat_deg, lat_sub, lat, d, m, h, lonv, sp, dc, se, speed, course;
    fx = '0;
    ok = r.bytes.data_type inside {TYPE_CUR_GPS, TYPE_OLD_GPS, TYPE_CUR_RSV, TYPE_OLD_RSV};
    for (int i = 0; i < NumAddrChars; i++) begin
      ch     = r.bytes.dest_chars[47 - 8 * i -: 8];
      dig[i] = -1;
      flg[i] = 1'b0;
      cus[i] = 1'b0;
      if (ch >= CHR_ZERO && ch <= CHR_ZERO + 8'd9) begin
        dig[i] = int'(ch - CHR_ZERO);
      end else if (ch >= CHR_A && ch <= CHR_A + 8'd9) begin
        dig[i] = int'(ch - CHR_A);
        flg[i] = 1'b1;
        cus[i] = 1'b1;
      end else if (ch == CHR_K) begin
        flg[i] = 1'b1;
        cus[i] = 1'b1;
      end else if (ch >= CHR_P && ch <= CHR_P + 8'd9) begin
        dig[i] = int'(ch - CHR_P);
        flg[i] = 1'b1;
      end else if (ch == CHR_Z) begin
        flg[i] = 1'b1;
      end else if (ch != CHR_L) begin
        ok = 1'b0;
      end
      val[i] = (dig[i] < 0) ? 0 : dig[i];
    end
    if (!ok) begin
      return fx;
    end

    lat_deg = val[0] * 10 + val[1];
    lat_sub = (val[2] * 10 + val[3]) * 100 + val[4] * 10 + val[5];
    lat     = lat_deg * 6000 + lat_sub;
    if (!flg[3]) begin
      lat = -lat;
    end
    if (dig[5] < 0) begin
      fx.f.ambiguity = 3'd1;
      if (dig[4] < 0) begin
        fx.f.ambiguity = 3'd2;
        if (dig[3] < 0) begin
          fx.f.ambiguity = (dig[2] < 0) ? 3'd4 : 3'd3;
        end
      end
    end

    sel     = {1'b0, flg[0], flg[1], flg[2]};
    any_std = (flg[0] && !cus[0]) || (flg[1] && !cus[1]) || (flg[2] && !cus[2]);
    any_cus = (flg[0] && cus[0]) || (flg[1] && cus[1]) || (flg[2] && cus[2]);
    if (sel == 4'd0) begin
      fx.f.msg_code = MSG_EMERGENCY;
    end else if (any_std && any_cus) begin
      fx.f.msg_code = MSG_UNKNOWN;
    end else begin
      fx.f.msg_code       = MSG_EMERGENCY - sel;
      fx.f.custom_message = any_cus;
    end

    d = int'(r.bytes.lon_bytes[23:16]) - 28;
    if (flg[4]) begin
      d += 100;
    end
    if (d >= 180 && d <= 189) begin
      d -= 80;
    end else if (d >= 190 && d <= 199) begin
      d -= 190;
    end
    m = int'(r.bytes.lon_bytes[15:8]) - 28;
    if (m >= 60) begin
      m -= 60;
    end
    h = int'(r.bytes.lon_bytes[7:0]) - 28;
    h = (h < 0) ? 0 : ((h > 99) ? 99 : h);
    lonv = d * 6000 + m * 100 + h;
    if (flg[5]) begin
      lonv = -lonv;
    end

    sp     = int'(r.bytes.speed_course[23:16]) - 28;
    dc     = int'(r.bytes.speed_course[15:8]) - 28;
    se     = int'(r.bytes.speed_course[7:0]) - 28;
    speed  = sp * 10 + dc / 10;
    course = (dc % 10) * 100 + se;
    if (speed >= 800) begin
      speed -= 800;
    end
    if (course >= 400) begin
      course -= 400;
    end
    if (speed < 0) begin
      speed = 0;
    end
    if (course < 0) begin
      course = 0;
    end

    fx.report_valid    = 1'b1;
    fx.f.latitude      = lat[20:0];
    fx.f.longitude     = lonv[21:0];
    fx.f.ground_speed  = speed[10:0];
    fx.f.heading       = course[9:0];
    fx.f.symbol_code   = r.bytes.symbol_bytes[15:8];
    fx.f.symbol_table  = r.bytes.symbol_bytes[7:0];
    fx.f.msg_support   = r.extra_present &&
                         (r.bytes.extra_byte inside {XTRA_BACKTICK, XTRA_GT, XTRA_RBRACKET});
    fx.f.null_position = (lat_deg == 0) && (lat_sub == 0);
    return fx;
  endfunction

  function automatic mic_e_report_t random_report();
    mic_e_report_t r;
    int unsigned   amb;
    int unsigned   pick;
    int unsigned   mode;
    logic [7:0]    ch;
    r.extra_present = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       r.bytes.data_type = 8'($urandom);
      1, 2:    r.bytes.data_type = TYPE_CUR_GPS;
      3, 4:    r.bytes.data_type = TYPE_OLD_GPS;
      5, 6:    r.bytes.data_type = TYPE_CUR_RSV;
      default: r.bytes.data_type = TYPE_OLD_RSV;
    endcase
    amb = ($urandom_range(2) == 0) ? $urandom_range(4) : 0;
    for (int i = 0; i < NumAddrChars; i++) begin
      pick = (i >= NumAddrChars - amb) ? 9 : $urandom_range(9);
      case (pick)
        0, 1, 2: ch = CHR_ZERO + 8'($urandom_range(9));
        3, 4:    ch = CHR_A + 8'($urandom_range(9));
        5, 6, 7: ch = CHR_P + 8'($urandom_range(9));
        default: begin
          case ($urandom_range(2))
            0:       ch = CHR_K;
            1:       ch = CHR_L;
            default: ch = CHR_Z;
          endcase
        end
      endcase
      r.bytes.dest_chars[47 - 8 * i -: 8] = ch;
    end
    mode = $urandom_range(99);
    if (mode >= 90) begin
      r.bytes.dest_chars = {16'($urandom), 32'($urandom)};
    end else if (mode >= 80) begin
      pick = $urandom_range(NumAddrChars - 1);
      r.bytes.dest_chars[47 - 8 * pick -: 8] = 8'($urandom);
    end
    if ($urandom_range(1) == 0) begin
      r.bytes.lon_bytes = 24'($urandom);
    end else begin
      r.bytes.lon_bytes = {8'(28 + $urandom_range(109)), 8'(28 + $urandom_range(69)),
                           8'(28 + $urandom_range(99))};
    end
    if ($urandom_range(1) == 0) begin
      r.bytes.speed_course = 24'($urandom);
    end else begin
      r.bytes.speed_course = {8'(28 + $urandom_range(109)), 8'(28 + $urandom_range(99)),
                              8'(28 + $urandom_range(99))};
    end
    r.bytes.symbol_bytes = 16'($urandom);
    case ($urandom_range(5))
      0:       r.bytes.extra_byte = XTRA_BACKTICK;
      1:       r.bytes.extra_byte = XTRA_GT;
      2:       r.bytes.extra_byte = XTRA_RBRACKET;
      default: r.bytes.extra_byte = 8'($urandom);
    endcase
    return r;
  endfunction

  function automatic logic [47:0] mk_dest(string s);
    logic [47:0] d;
    for (int i = 0; i < NumAddrChars; i++) begin
      d[47 - 8 * i -: 8] = s[i];
    end
    return d;
  endfunction

  function automatic stim_row_t mk_row(logic [47:0] dest, logic [7:0] dtype,
                                       logic [23:0] lon, logic [23:0] spc,
                                       logic [15:0] sym, logic [7:0] xb, logic xp,
                                       bit rejected);
    stim_row_t row;
    row.rpt.extra_present      = xp;
    row.rpt.bytes.dest_chars   = dest;
    row.rpt.bytes.data_type    = dtype;
    row.rpt.bytes.lon_bytes    = lon;
    row.rpt.bytes.speed_course = spc;
    row.rpt.bytes.symbol_bytes = sym;
    row.rpt.bytes.extra_byte   = xb;
    row.typed                  = rejected;
    row.fix                    = '0;
    return row;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic send_report(mic_e_report_t r, bit typed, position_fix_t fix);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.bytes;
    s_axis_tuser  <= r.extra_present;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_fixes.push_back(typed ? fix : decode_fix(r));
    reports_sent++;
  endtask

  task automatic wait_for_fixes();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_fixes.size() != 0);
  endtask

  initial begin : output_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_fix = {m_axis_tuser, m_axis_tdata[89:0]};
      if (pending_fixes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual tuser %0b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want_fix = pending_fixes.pop_front();
        results_checked++;
        if (want_fix.report_valid) begin
          fixes_valid++;
        end
        cmp_field("report_valid", want_fix.report_valid, seen_fix.report_valid);
        cmp_field("latitude_hmin", want_fix.f.latitude, seen_fix.f.latitude);
        cmp_field("longitude_hmin", want_fix.f.longitude, seen_fix.f.longitude);
        cmp_field("ambiguity_level", want_fix.f.ambiguity, seen_fix.f.ambiguity);
        cmp_field("msg_code", want_fix.f.msg_code, seen_fix.f.msg_code);
        cmp_field("custom_message", want_fix.f.custom_message, seen_fix.f.custom_message);
        cmp_field("ground_speed", want_fix.f.ground_speed, seen_fix.f.ground_speed);
        cmp_field("heading", want_fix.f.heading, seen_fix.f.heading);
        cmp_field("symbol_code", want_fix.f.symbol_code, seen_fix.f.symbol_code);
        cmp_field("symbol_table", want_fix.f.symbol_table, seen_fix.f.symbol_table);
        cmp_field("msg_support", want_fix.f.msg_support, seen_fix.f.msg_support);
        cmp_field("null_position", want_fix.f.null_position, seen_fix.f.null_position);
        cmp_field("tdata fill", 32'd0, m_axis_tdata[95:90]);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows[$];
    int unsigned count;
    rows.push_back(mk_row(48'h0, 8'h00, 24'h0, 24'h0, 16'h0000, 8'h00, 1'b0, 1'b1));
    rows.push_back(mk_row('1, 8'hff, '1, '1, '1, 8'hff, 1'b1, 1'b1));
    rows.push_back(mk_row(mk_dest("4903PX"), TYPE_CUR_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_BACKTICK, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903PX"), 8'h61, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b1));
    rows.push_back(mk_row(mk_dest("M903PX"), TYPE_OLD_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b1));
    rows.push_back(mk_row(mk_dest("49:3PX"), TYPE_CUR_RSV, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b1));
    rows.push_back(mk_row(mk_dest("49030a"), TYPE_OLD_RSV, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b1));
    rows.push_back(mk_row(mk_dest("490312"), TYPE_OLD_GPS, {8'd40, 8'd30, 8'd50},
                          {8'd28, 8'd28, 8'd28}, 16'hff00, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("ABJ3PX"), TYPE_CUR_RSV, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h00ff, XTRA_RBRACKET, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("AP03PX"), TYPE_OLD_RSV, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h5a5a, XTRA_BACKTICK, 1'b0, 1'b0));
    rows.push_back(mk_row(mk_dest("4903PZ"), TYPE_CUR_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'ha5a5, 8'h3f, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903ZK"), TYPE_CUR_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b0, 1'b0));
    rows.push_back(mk_row(mk_dest("490LKZ"), TYPE_OLD_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("49LLLL"), TYPE_OLD_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("000000"), TYPE_CUR_GPS, {8'd28, 8'd28, 8'd28},
                          {8'd28, 8'd28, 8'd28}, 16'h0000, 8'h00, 1'b0, 1'b0));
    rows.push_back(mk_row(mk_dest("LLLLLL"), TYPE_CUR_GPS, {8'd28, 8'd28, 8'd28},
                          {8'd28, 8'd28, 8'd28}, 16'h0000, 8'h00, 1'b0, 1'b0));
    rows.push_back(mk_row(mk_dest("4903QX"), TYPE_CUR_GPS, {8'd113, 8'd58, 8'd73},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903QX"), TYPE_CUR_GPS, {8'd123, 8'd93, 8'd255},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903QX"), TYPE_CUR_GPS, {8'd0, 8'd0, 8'd0},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("490300"), TYPE_CUR_GPS, {8'd0, 8'd255, 8'd0},
                          {8'd30, 8'd62, 8'd118}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903PX"), TYPE_CUR_GPS, {8'd140, 8'd58, 8'd73},
                          {8'd113, 8'd32, 8'd60}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("4903PX"), TYPE_CUR_RSV, {8'd140, 8'd58, 8'd73},
                          {8'd0, 8'd0, 8'd0}, 16'h3e2f, XTRA_GT, 1'b1, 1'b0));
    rows.push_back(mk_row(mk_dest("Y9J9Y9"), TYPE_OLD_RSV, {8'd255, 8'd255, 8'd255},
                          {8'd255, 8'd255, 8'd255}, 16'hffff, 8'hff, 1'b1, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      send_report(rows[k].rpt, rows[k].typed, rows[k].fix);
    end
    directed_count = rows.size();

    for (int p = 0; p < RandomPhases; p++) begin
      wait_for_fixes();
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          count     = 350;
        end
        1: begin
          idle_pct  = 87;
          stall_pct = 0;
          count     = 300;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 87;
          count     = 300;
        end
        3: begin
          idle_pct  = 19;
          stall_pct = 19;
          count     = 450;
        end
        default: begin
          idle_pct         = 0;
          stall_pct        = 0;
          count            = 350;
          hold_off_request = LongHoldCycles;
        end
      endcase
      repeat (count) begin
        if (p == 3 && $urandom_range(99) == 0) begin
          wait_for_fixes();
        end
        send_report(random_report(), 1'b0, '0);
      end
    end

    stall_pct = 0;
    wait_for_fixes();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d reports sent (%0d directed, rest random over five idle/stall mixes),",
             reports_sent, directed_count);
    $display("%0d results checked: %0d decoded, %0d rejected; long output hold-off included",
             results_checked, fixes_valid, results_checked - fixes_valid);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
